### rtl/vgm_pkg.sv
package vgm_pkg;

  localparam int unsigned PosW = 27;
  localparam int unsigned OffW = 33;
  localparam logic [PosW-1:0] MaxFileBytes = 27'd67108864;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_OPCODE,
    PH_BLOCK,
    PH_DONE
  } phase_e;

  localparam logic [4:0] FailNone = 5'd31;

  localparam logic [4:0] RsnNotVgm      = 5'd0;
  localparam logic [4:0] RsnBadBounds   = 5'd1;
  localparam logic [4:0] RsnBadVersion  = 5'd2;
  localparam logic [4:0] RsnBadBlock    = 5'd3;
  localparam logic [4:0] RsnSecondChip  = 5'd4;
  localparam logic [4:0] RsnShortRom    = 5'd5;
  localparam logic [4:0] RsnUnsupported = 5'd6;
  localparam logic [4:0] RsnTruncated   = 5'd7;
  localparam logic [4:0] RsnNoEnd       = 5'd8;
  localparam logic [4:0] RsnBoth        = 5'd9;
  localparam logic [4:0] RsnBadType     = 5'd10;
  localparam logic [4:0] RsnNoUsage     = 5'd11;
  localparam logic [4:0] RsnBClock      = 5'd12;
  localparam logic [4:0] RsnBDual       = 5'd13;
  localparam logic [4:0] RsnBOffset     = 5'd14;
  localparam logic [4:0] RsnB           = 5'd15;
  localparam logic [4:0] RsnNoClock     = 5'd16;
  localparam logic [4:0] RsnDual        = 5'd17;
  localparam logic [4:0] RsnA           = 5'd18;
  localparam logic [4:0] RsnOversize    = 5'd19;

  typedef struct packed {
    logic [2:0]  profile;
    logic [4:0]  reason;
    logic [26:0] command_count;
    logic [25:0] fail_offset;
    logic [7:0]  fail_opcode;
  } verdict_t;

  function automatic logic [2:0] profile_of(input logic [4:0] r);
    logic [2:0] p;
    unique case (r)
      RsnBadVersion, RsnSecondChip, RsnUnsupported, RsnBadType, RsnBDual, RsnBOffset,
      RsnDual: p = 3'd2;
      RsnBoth, RsnNoUsage: p = 3'd3;
      RsnB: p = 3'd1;
      RsnA: p = 3'd0;
      default: p = 3'd4;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] clock_addr(input int unsigned i);
    logic [7:0] a;
    unique case (i)
      0: a = 8'h0c;
      1: a = 8'h2c;
      2: a = 8'h30;
      3: a = 8'h44;
      4: a = 8'h38;
      default: a = 8'h4c;
    endcase
    return a;
  endfunction

endpackage

### rtl/vgm_verdict.sv
module vgm_verdict (
  input  logic                   valid_i,
  input  logic                   over_i,
  input  logic [vgm_pkg::PosW-1:0] size_i,
  input  logic                   magic_ok_i,
  input  logic [vgm_pkg::OffW-1:0] end_offset_i,
  input  logic [vgm_pkg::OffW-1:0] data_offset_i,
  input  logic [vgm_pkg::OffW-1:0] loop_offset_i,
  input  logic [31:0]            version_i,
  input  logic                   raw_zero_i,
  input  logic [4:0]             first_failure_i,
  input  logic                   fa_i,
  input  logic                   fb_i,
  input  logic                   fend_i,
  input  logic                   floop_i,
  input  logic                   fbadtype_i,
  input  logic [4:0]             used_i,
  input  logic [5:0][31:0]       clock_i,
  input  logic [26:0]            commands_i,
  input  logic [25:0]            fail_pos_i,
  input  logic [7:0]             fail_op_i,
  output vgm_pkg::verdict_t      verdict_o
);
  import vgm_pkg::*;

  logic [5:0][31:0] clk_eff;
  logic [4:0]       r;
  logic             chip_noclk;
  logic             chip_dual;
  logic             chip_bad;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      clk_eff[i] = ({25'd0, clock_addr(i)} + 33'd4 <= data_offset_i) ? clock_i[i] : 32'd0;
    end
  end

  always_comb begin
    chip_bad = 1'b0;
    chip_noclk = 1'b0;
    chip_dual = 1'b0;
    for (int i = 0; i < 5; i++) begin
      if (used_i[i] && !chip_bad) begin
        if (clk_eff[i][29:0] == 30'd0) begin
          chip_noclk = 1'b1;
          chip_bad = 1'b1;
        end else if (clk_eff[i][30]) begin
          chip_dual = 1'b1;
          chip_bad = 1'b1;
        end
      end
    end
  end

  always_comb begin
    priority if (over_i) r = RsnOversize;
    else if (size_i < 27'd64 || !magic_ok_i) r = RsnNotVgm;
    else if (end_offset_i > {6'd0, size_i} || data_offset_i < 33'd64 ||
             data_offset_i >= end_offset_i) r = RsnBadBounds;
    else if (version_i < 32'h110 || version_i > 32'h171) r = RsnBadVersion;
    else if (first_failure_i != FailNone) r = first_failure_i;
    else if (!fend_i || !(loop_offset_i == 33'd0 || floop_i)) r = RsnNoEnd;
    else if (fa_i && fb_i) r = RsnBoth;
    else if (fbadtype_i) r = RsnBadType;
    else if (!fa_i && !fb_i) r = RsnNoUsage;
    else if (fb_i) begin
      priority if (clk_eff[5][29:0] == 30'd0) r = RsnBClock;
      else if (clk_eff[5][30]) r = RsnBDual;
      else if (version_i >= 32'h150 && raw_zero_i) r = RsnBOffset;
      else r = RsnB;
    end
    else if (chip_noclk) r = RsnNoClock;
    else if (chip_dual) r = RsnDual;
    else r = RsnA;
  end

  always_comb begin
    verdict_o.reason = r;
    verdict_o.profile = profile_of(r);
    verdict_o.command_count = (r <= RsnBadVersion || r == RsnOversize || !valid_i) ?
                              27'd0 : commands_i;
    verdict_o.fail_offset = (r == RsnUnsupported) ? fail_pos_i : 26'd0;
    verdict_o.fail_opcode = (r == RsnUnsupported) ? fail_op_i : 8'd0;
  end

endmodule

### rtl/vgm_stream_profile_classifier.sv
// VGM stream profile classifier.
// The slave channel takes one word per cycle while s_axis_tready is high: the bytes of
// one uncompressed VGM file in file order, with s_axis_tlast on the final byte.
// No result is produced for other bytes. When the last byte is taken, the block decides
// the profile of the whole file, and one verdict word appears on the master channel in
// the following cycle. The state is then cleared for the next file.
// Each byte is handled by the header capture and command walk logic as it is taken, so
// the block sustains one byte per cycle while s_axis_tready is high. The verdict is
// computed from the state after the last byte and held in a one-entry output register.
// When the receiver stalls with a verdict pending, the block keeps taking bytes of the
// next file until another last byte would need the output register; then s_axis_tready
// drops until the pending verdict is taken.
// After reset the block waits for the first byte of a file with no verdict pending.
module vgm_stream_profile_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // profile, reason, command_count, fail_offset,
                                      // fail_opcode, zero fill
);
  import vgm_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     shift_q, shift_d;
  logic            magic_q, magic_d;
  logic [OffW-1:0] end_q, end_d, doff_q, doff_d, loop_q, loop_d, npc_q, npc_d;
  logic [31:0]     ver_q, ver_d;
  logic            rawz_q, rawz_d;
  logic [5:0][31:0] clk_q, clk_d;
  phase_e          ph_q, ph_d;
  logic [7:0]      btype_q, btype_d;
  logic [31:0]     blen_q, blen_d;
  logic            fa_q, fa_d, fb_q, fb_d, fend_q, fend_d, floop_q, floop_d;
  logic            fbt_q, fbt_d, fover_q, fover_d;
  logic [4:0]      used_q, used_d;
  logic [26:0]     cmds_q, cmds_d;
  logic [4:0]      ff_q, ff_d;
  logic [25:0]     fpos_q, fpos_d;
  logic [7:0]      fop_q, fop_d;
  logic            ovalid_q;
  verdict_t        ores_q, vres;

  logic accept, fin;
  logic [7:0] c;
  logic [OffW-1:0] idx, bsize;
  logic [31:0] w, nlen;
  logic [OffW-1:0] size;
  logic ok;
  logic [1:0] fl;
  logic [4:0] used;

  assign s_axis_tready = !ovalid_q || m_axis_tready || !s_axis_tlast;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign c = s_axis_tdata;
  assign idx = {6'd0, pos_q};
  assign w = {c, shift_q[31:8]};
  assign nlen = {c, blen_q[31:8]};

  always_comb begin
    ok = 1'b1;
    fl = 2'd0;
    used = 5'd0;
    size = 33'd1;
    unique casez (c)
      8'h61: size = 33'd3;
      8'h62, 8'h63, 8'b0111_????: size = 33'd1;
      8'h58, 8'h59: begin fl = 2'b10; size = 33'd3; end
      8'h4f, 8'h50: begin fl = 2'b01; used = 5'd1; size = 33'd2; end
      8'h52, 8'h53: begin fl = 2'b01; used = 5'd2; size = 33'd3; end
      8'h54: begin fl = 2'b01; used = 5'd4; size = 33'd3; end
      8'h55: begin fl = 2'b01; used = 5'd8; size = 33'd3; end
      8'hc0: begin fl = 2'b01; used = 5'd16; size = 33'd4; end
      8'b1000_????: begin fl = 2'b01; used = 5'd2; size = 33'd1; end
      8'he0: begin fl = 2'b01; used = 5'd2; size = 33'd5; end
      default: ok = 1'b0;
    endcase
  end

  assign bsize = 33'd7 + {1'b0, nlen};

  always_comb begin
    pos_d = pos_q; shift_d = shift_q; magic_d = magic_q; end_d = end_q; doff_d = doff_q;
    loop_d = loop_q; npc_d = npc_q; ver_d = ver_q; rawz_d = rawz_q; clk_d = clk_q;
    ph_d = ph_q; btype_d = btype_q; blen_d = blen_q; fa_d = fa_q; fb_d = fb_q;
    fend_d = fend_q; floop_d = floop_q; fbt_d = fbt_q; fover_d = fover_q; used_d = used_q;
    cmds_d = cmds_q; ff_d = ff_q; fpos_d = fpos_q; fop_d = fop_q;
    if (pos_q >= MaxFileBytes) begin
      fover_d = 1'b1;
    end else begin
      pos_d = pos_q + 27'd1;
      if (pos_q < 27'h50) begin
        shift_d = w;
        if (pos_q == 27'd3) magic_d = (w == 32'h206d6756);
        if (pos_q == 27'd7) end_d = {1'b0, w} + 33'd4;
        if (pos_q == 27'd11) ver_d = w;
        if (pos_q == 27'h1f) loop_d = (w != 32'd0) ? {1'b0, w} + 33'h1c : 33'd0;
        if (pos_q == 27'h37) begin
          rawz_d = (w == 32'd0);
          doff_d = (ver_q < 32'h150 || w == 32'd0) ? 33'd64 : {1'b0, w} + 33'h34;
          if (doff_d >= 33'd64) begin
            npc_d = doff_d;
            ph_d = PH_OPCODE;
          end
        end
        for (int i = 0; i < 6; i++) begin
          if (pos_q == {19'd0, clock_addr(i)} + 27'd3) clk_d[i] = w;
        end
      end
      if (ph_q == PH_OPCODE && idx == npc_q) begin
        if (idx >= end_q) begin
          ph_d = PH_DONE;
        end else begin
          if (idx == loop_q) floop_d = 1'b1;
          cmds_d = cmds_q + 27'd1;
          if (c == 8'h66) begin
            fend_d = 1'b1;
            ph_d = PH_DONE;
          end else if (c == 8'h67) begin
            if (idx + 33'd7 > end_q) begin
              ff_d = RsnBadBlock; fpos_d = '0; fop_d = '0; ph_d = PH_DONE;
            end else begin
              blen_d = '0;
              ph_d = PH_BLOCK;
            end
          end else if (!ok) begin
            ff_d = RsnUnsupported; fpos_d = pos_q[25:0]; fop_d = c; ph_d = PH_DONE;
          end else if (size > end_q - idx) begin
            ff_d = RsnTruncated; fpos_d = '0; fop_d = '0; ph_d = PH_DONE;
          end else begin
            fa_d = fa_q | fl[0];
            fb_d = fb_q | fl[1];
            used_d = used_q | used;
            npc_d = idx + size;
          end
        end
      end else if (ph_q == PH_BLOCK && idx > npc_q) begin
        if (idx - npc_q == 33'd1) begin
          if (c != 8'h66) begin
            ff_d = RsnBadBlock; fpos_d = '0; fop_d = '0; ph_d = PH_DONE;
          end
        end else if (idx - npc_q == 33'd2) begin
          btype_d = c;
        end else begin
          blen_d = nlen;
          if (idx - npc_q == 33'd6) begin
            priority if (nlen[31]) begin
              ff_d = RsnSecondChip; fpos_d = '0; fop_d = '0; ph_d = PH_DONE;
            end else if (btype_q >= 8'h80 && nlen < 32'd8) begin
              ff_d = RsnShortRom; fpos_d = '0; fop_d = '0; ph_d = PH_DONE;
            end else if (bsize > end_q - npc_q) begin
              ff_d = RsnTruncated; fpos_d = '0; fop_d = '0; ph_d = PH_DONE;
            end else begin
              priority if (btype_q == 8'h82 || btype_q == 8'h83) fb_d = 1'b1;
              else if (btype_q == 8'h80) begin fa_d = 1'b1; used_d = used_q | 5'd16; end
              else if (btype_q == 8'h00) begin fa_d = 1'b1; used_d = used_q | 5'd2; end
              else fbt_d = 1'b1;
              npc_d = npc_q + bsize;
              ph_d = PH_OPCODE;
            end
          end
        end
      end
    end
  end

  assign fin = accept && s_axis_tlast;

  vgm_verdict u_verdict (
    .valid_i        (1'b1),
    .over_i         (fover_d),
    .size_i         (pos_d),
    .magic_ok_i     (magic_d),
    .end_offset_i   (end_d),
    .data_offset_i  (doff_d),
    .loop_offset_i  (loop_d),
    .version_i      (ver_d),
    .raw_zero_i     (rawz_d),
    .first_failure_i(ff_d),
    .fa_i           (fa_d),
    .fb_i           (fb_d),
    .fend_i         (fend_d),
    .floop_i        (floop_d),
    .fbadtype_i     (fbt_d),
    .used_i         (used_d),
    .clock_i        (clk_d),
    .commands_i     (cmds_d),
    .fail_pos_i     (fpos_d),
    .fail_op_i      (fop_d),
    .verdict_o      (vres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; shift_q <= '0; magic_q <= 1'b0; end_q <= '0; doff_q <= 33'd64;
      loop_q <= '0; npc_q <= '0; ver_q <= '0; rawz_q <= 1'b1; clk_q <= '0;
      ph_q <= PH_IDLE; btype_q <= '0; blen_q <= '0; fa_q <= 1'b0; fb_q <= 1'b0;
      fend_q <= 1'b0; floop_q <= 1'b0; fbt_q <= 1'b0; fover_q <= 1'b0; used_q <= '0;
      cmds_q <= '0; ff_q <= FailNone; fpos_q <= '0; fop_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (fin) begin
        pos_q <= '0; shift_q <= '0; magic_q <= 1'b0; end_q <= '0; doff_q <= 33'd64;
        loop_q <= '0; npc_q <= '0; ver_q <= '0; rawz_q <= 1'b1; clk_q <= '0;
        ph_q <= PH_IDLE; btype_q <= '0; blen_q <= '0; fa_q <= 1'b0; fb_q <= 1'b0;
        fend_q <= 1'b0; floop_q <= 1'b0; fbt_q <= 1'b0; fover_q <= 1'b0; used_q <= '0;
        cmds_q <= '0; ff_q <= FailNone; fpos_q <= '0; fop_q <= '0;
      end else if (accept) begin
        pos_q <= pos_d; shift_q <= shift_d; magic_q <= magic_d; end_q <= end_d;
        doff_q <= doff_d; loop_q <= loop_d; npc_q <= npc_d; ver_q <= ver_d;
        rawz_q <= rawz_d; clk_q <= clk_d; ph_q <= ph_d; btype_q <= btype_d;
        blen_q <= blen_d; fa_q <= fa_d; fb_q <= fb_d; fend_q <= fend_d;
        floop_q <= floop_d; fbt_q <= fbt_d; fover_q <= fover_d; used_q <= used_d;
        cmds_q <= cmds_d; ff_q <= ff_d; fpos_q <= fpos_d; fop_q <= fop_d;
      end
      if (fin) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) ores_q <= vres;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {3'd0, ores_q.fail_opcode, ores_q.fail_offset, ores_q.command_count,
                         ores_q.reason, ores_q.profile};

  assert property (@(posedge clk_i) disable iff (!rst_ni) fin |=> m_axis_tvalid)
    else $error("verdict not presented after last byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending verdict lost or changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni) fin |=> pos_q == '0 && ff_q == FailNone)
    else $error("state not cleared after verdict");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !m_axis_tready && s_axis_tlast |-> !s_axis_tready)
    else $error("verdict would be overwritten");

endmodule

### bench/vgm_stream_profile_classifier_tb.sv
module vgm_stream_profile_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vgm_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam longint unsigned FileCap = 64'd67108864;

  localparam bit [7:0] OpEnd = 8'h66;
  localparam bit [7:0] OpBlock = 8'h67;
  localparam bit [7:0] OpWaitN = 8'h61;
  localparam bit [7:0] OpWait60 = 8'h62;
  localparam bit [7:0] OpWait50 = 8'h63;
  localparam bit [7:0] OpWaitShort = 8'h70;
  localparam bit [7:0] OpFmWrite = 8'h52;
  localparam bit [7:0] OpBWrite = 8'h58;
  localparam bit [7:0] OpBWrite2 = 8'h59;
  localparam bit [7:0] OpPcmSeek = 8'he0;
  localparam bit [7:0] OpBogus = 8'h30;

  localparam bit [7:0] BlkFmPcm = 8'h00;
  localparam bit [7:0] BlkRomA = 8'h80;
  localparam bit [7:0] BlkBadType = 8'h81;
  localparam bit [7:0] BlkRomB = 8'h82;
  localparam bit [7:0] BlkRomB2 = 8'h83;

  localparam bit [9:0] FlA = 10'd1;
  localparam bit [9:0] FlB = 10'd2;
  localparam bit [9:0] FlEnd = 10'd4;
  localparam bit [9:0] FlLoop = 10'd8;
  localparam bit [9:0] FlBadType = 10'd16;
  localparam bit [9:0] FlOver = 10'd32;

  localparam int ClkAddr[6] = '{'h0c, 'h2c, 'h30, 'h44, 'h38, 'h4c};

  localparam int BodyEnd = 0;
  localparam int BodyA = 1;
  localparam int BodyB = 2;
  localparam int BodyAB = 3;
  localparam int BodyBadOp = 4;
  localparam int BodyTrunc = 5;
  localparam int BodyNoEnd = 6;
  localparam int BodyBadType = 7;
  localparam int BodySecond = 8;
  localparam int BodyShortRom = 9;
  localparam int BodyBadMark = 10;
  localparam int BodyTail = 11;
  localparam int BodyPcm = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [71:0] m_axis_tdata;

  vgm_stream_profile_classifier i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  typedef struct {
    bit        fixed;
    verdict_t  v;
  } pinned_t;

  typedef struct {
    bit [31:0] ver;
    bit [31:0] draw;
    int        body;
    int        clk_idx;
    bit [31:0] clk_val;
    int        loop_rel;
    int        end_adj;
    bit        bad_magic;
    int        short_len;
    bit        fixed;
    bit [2:0]  prof;
    logic [4:0] rsn;
  } drow_t;

  verdict_t  verdict_q[$];
  pinned_t   pinned_q[$];
  int        errors = 0;
  int        verdicts_seen = 0;
  int        bytes_sent = 0;
  int unsigned cycle = 0;
  bit        hold = 1'b0;
  bit        calm;

  bit [7:0]  bq[$];
  bit [7:0]  fb[];
  bit [31:0] ck[6];

  // Classifier state mirrored from the behavior of the block.
  longint unsigned p_pos, p_end, p_data, p_loop, p_next;
  bit [31:0] p_shift, p_ver, p_blen;
  bit [31:0] p_clk[6];
  bit        p_magic, p_raw0;
  phase_e    p_phase;
  bit [7:0]  p_btype;
  bit [9:0]  p_flags;
  bit [4:0]  p_used;
  bit [26:0] p_cmds;
  logic [4:0] p_fail;
  bit [25:0] p_fpos;
  bit [7:0]  p_fop;

  function automatic void clear_walk();
    p_pos = 0; p_shift = 0; p_magic = 0; p_end = 0; p_ver = 0; p_data = 64;
    p_raw0 = 1; p_loop = 0; p_next = 0; p_phase = PH_IDLE; p_btype = 0; p_blen = 0;
    p_flags = 0; p_used = 0; p_cmds = 0; p_fail = FailNone; p_fpos = 0; p_fop = 0;
    for (int i = 0; i < 6; i++) p_clk[i] = 0;
  endfunction

  function automatic void latch_failure(logic [4:0] code, longint unsigned pos,
                                        bit [7:0] op);
    p_fail = code;
    p_fpos = pos[25:0];
    p_fop = op;
    p_phase = PH_DONE;
  endfunction

  function automatic bit [31:0] clock_seen(int i);
    return (longint'(ClkAddr[i]) + 4 <= p_data) ? p_clk[i] : 32'd0;
  endfunction

  function automatic void grab_header(longint unsigned idx, bit [7:0] c);
    p_shift = {c, p_shift[31:8]};
    if (idx == 3) p_magic = (p_shift == 32'h206d6756);
    else if (idx == 7) p_end = {32'd0, p_shift} + 64'd4;
    else if (idx == 11) p_ver = p_shift;
    else if (idx == 'h1f) p_loop = (p_shift != 0) ? {32'd0, p_shift} + 64'h1c : 64'd0;
    else if (idx == 'h37) begin
      p_raw0 = (p_shift == 0);
      p_data = (p_ver < 'h150 || p_shift == 0) ? 64'd64 : {32'd0, p_shift} + 64'h34;
      if (p_data >= 64) begin
        p_next = p_data;
        p_phase = PH_OPCODE;
      end
    end
    for (int i = 0; i < 6; i++)
      if (idx == longint'(ClkAddr[i] + 3)) p_clk[i] = p_shift;
  endfunction

  function automatic void walk_opcode(longint unsigned pc, bit [7:0] c);
    longint unsigned sz;
    bit [9:0] fl;
    bit [4:0] used;
    sz = 1; fl = 0; used = 0;
    if (pc >= p_end) begin
      p_phase = PH_DONE;
      return;
    end
    if (pc == p_loop) p_flags |= FlLoop;
    p_cmds++;
    if (c == OpEnd) begin
      p_flags |= FlEnd;
      p_phase = PH_DONE;
      return;
    end
    if (c == OpBlock) begin
      if (pc + 7 > p_end) latch_failure(RsnBadBlock, 0, 0);
      else begin
        p_blen = 0;
        p_phase = PH_BLOCK;
      end
      return;
    end
    if (c == OpWaitN) sz = 3;
    else if (c == OpWait60 || c == OpWait50 || c inside {[8'h70:8'h7f]}) sz = 1;
    else if (c == OpBWrite || c == OpBWrite2) begin fl = FlB; sz = 3; end
    else if (c == 8'h4f || c == 8'h50) begin fl = FlA; used = 1; sz = 2; end
    else if (c == OpFmWrite || c == 8'h53) begin fl = FlA; used = 2; sz = 3; end
    else if (c == 8'h54) begin fl = FlA; used = 4; sz = 3; end
    else if (c == 8'h55) begin fl = FlA; used = 8; sz = 3; end
    else if (c == 8'hc0) begin fl = FlA; used = 16; sz = 4; end
    else if (c inside {[8'h80:8'h8f]}) begin fl = FlA; used = 2; sz = 1; end
    else if (c == OpPcmSeek) begin fl = FlA; used = 2; sz = 5; end
    else begin
      latch_failure(RsnUnsupported, pc, c);
      return;
    end
    if (sz > p_end - pc) begin
      latch_failure(RsnTruncated, 0, 0);
      return;
    end
    p_flags |= fl;
    p_used |= used;
    p_next = pc + sz;
  endfunction

  function automatic void walk_block(longint unsigned idx, bit [7:0] c);
    longint unsigned off, sz;
    off = idx - p_next;
    if (off == 1) begin
      if (c != OpEnd) latch_failure(RsnBadBlock, 0, 0);
      return;
    end
    if (off == 2) begin
      p_btype = c;
      return;
    end
    p_blen = {c, p_blen[31:8]};
    if (off != 6) return;
    if (p_blen[31]) begin latch_failure(RsnSecondChip, 0, 0); return; end
    if (p_btype >= 8'h80 && p_blen < 8) begin latch_failure(RsnShortRom, 0, 0); return; end
    sz = 64'd7 + {32'd0, p_blen};
    if (sz > p_end - p_next) begin latch_failure(RsnTruncated, 0, 0); return; end
    if (p_btype == BlkRomB || p_btype == BlkRomB2) p_flags |= FlB;
    else if (p_btype == BlkRomA) begin p_flags |= FlA; p_used |= 5'd16; end
    else if (p_btype == BlkFmPcm) begin p_flags |= FlA; p_used |= 5'd2; end
    else p_flags |= FlBadType;
    p_next = p_next + sz;
    p_phase = PH_OPCODE;
  endfunction

  function automatic logic [4:0] decide(longint unsigned sz);
    bit a, b;
    bit [31:0] k;
    a = (p_flags & FlA) != 0;
    b = (p_flags & FlB) != 0;
    if (p_flags & FlOver) return RsnOversize;
    if (sz < 64 || !p_magic) return RsnNotVgm;
    if (p_end > sz || p_data < 64 || p_data >= p_end) return RsnBadBounds;
    if (p_ver < 'h110 || p_ver > 'h171) return RsnBadVersion;
    if (p_fail != FailNone) return p_fail;
    if (!(p_flags & FlEnd) || !(p_loop == 0 || (p_flags & FlLoop))) return RsnNoEnd;
    if (a && b) return RsnBoth;
    if (p_flags & FlBadType) return RsnBadType;
    if (!a && !b) return RsnNoUsage;
    if (b) begin
      k = clock_seen(5);
      if (k[29:0] == 0) return RsnBClock;
      if (k[30]) return RsnBDual;
      if (p_ver >= 'h150 && p_raw0) return RsnBOffset;
      return RsnB;
    end
    for (int i = 0; i < 5; i++)
      if (p_used[i]) begin
        k = clock_seen(i);
        if (k[29:0] == 0) return RsnNoClock;
        if (k[30]) return RsnDual;
      end
    return RsnA;
  endfunction

  function automatic bit [2:0] profile_for(logic [4:0] r);
    case (r)
      RsnA: return 3'd0;
      RsnB: return 3'd1;
      RsnBadVersion, RsnSecondChip, RsnUnsupported, RsnBadType, RsnBDual, RsnBOffset,
      RsnDual: return 3'd2;
      RsnBoth, RsnNoUsage: return 3'd3;
      default: return 3'd4;
    endcase
  endfunction

  function automatic void classify_byte(bit [7:0] c, bit lst);
    longint unsigned idx;
    logic [4:0] r;
    verdict_t v;
    pinned_t pin;
    idx = p_pos;
    if (idx >= FileCap) p_flags |= FlOver;
    else begin
      p_pos = idx + 1;
      if (idx < 'h50) grab_header(idx, c);
      if (p_phase == PH_OPCODE && idx == p_next) walk_opcode(idx, c);
      else if (p_phase == PH_BLOCK && idx > p_next) walk_block(idx, c);
    end
    if (!lst) return;
    r = decide(p_pos);
    v.profile = profile_for(r);
    v.reason = r;
    v.command_count = (r <= RsnBadVersion || r == RsnOversize) ? 27'd0 : p_cmds;
    v.fail_offset = (r == RsnUnsupported) ? p_fpos : 26'd0;
    v.fail_opcode = (r == RsnUnsupported) ? p_fop : 8'd0;
    pin = pinned_q.pop_front();
    verdict_q.push_back(pin.fixed ? pin.v : v);
    clear_walk();
  endfunction

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  assign calm = (cycle >= 3000 && cycle < 6000);

  always @(posedge clk_i) begin
    if (rst_ni && s_valid && s_axis_tready) classify_byte(s_data, s_last);
  end

  always @(posedge clk_i) m_ready <= !hold && (calm || $urandom_range(99) >= 13);

  always @(posedge clk_i) begin
    verdict_t e;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      verdicts_seen <= verdicts_seen + 1;
      if (verdict_q.size() == 0) begin
        $display("%t unexpected word %h", $realtime, m_axis_tdata);
        errors <= errors + 1;
      end else begin
        e = verdict_q.pop_front();
        if (m_axis_tdata[2:0] !== e.profile || m_axis_tdata[7:3] !== e.reason ||
            m_axis_tdata[34:8] !== e.command_count ||
            m_axis_tdata[60:35] !== e.fail_offset ||
            m_axis_tdata[68:61] !== e.fail_opcode) begin
          $display("%t mismatch: expected profile %0d reason %0d count %0d offset %0d op %0h",
                   $realtime, e.profile, e.reason, e.command_count, e.fail_offset,
                   e.fail_opcode);
          $display("%t          actual   profile %0d reason %0d count %0d offset %0d op %0h",
                   $realtime, m_axis_tdata[2:0], m_axis_tdata[7:3], m_axis_tdata[34:8],
                   m_axis_tdata[60:35], m_axis_tdata[68:61]);
          errors <= errors + 1;
        end
      end
    end
  end

  // Long receiver stall so that a verdict stays pending and the input backs up.
  initial begin
    wait (verdicts_seen >= 3);
    hold = 1'b1;
    repeat (700) @(posedge clk_i);
    hold = 1'b0;
  end

  task automatic put_cmd(bit [7:0] op, int n);
    bq.push_back(op);
    repeat (n) bq.push_back(8'($urandom));
  endtask

  task automatic put_block(bit [7:0] mark, bit [7:0] kind, bit [31:0] len, int n);
    bq.push_back(OpBlock);
    bq.push_back(mark);
    bq.push_back(kind);
    for (int i = 0; i < 4; i++) bq.push_back(len[8*i +: 8]);
    repeat (n) bq.push_back(8'($urandom));
  endtask

  task automatic put32(int a, bit [31:0] v);
    for (int i = 0; i < 4; i++) if (a + i < fb.size()) fb[a+i] = v[8*i +: 8];
  endtask

  task automatic build_file(bit [31:0] ver, bit [31:0] draw, int loop_rel, int end_adj,
                            bit bad_magic, int short_len);
    longint unsigned ds;
    int base, len;
    ds = (ver < 'h150 || draw == 0) ? 64 : {32'd0, draw} + 64'h34;
    base = (ds > 512) ? 64 : ((ds < 64) ? 64 : int'(ds));
    if (ds < 64) base = int'(ds);
    len = ((base > 64) ? base : 64) + bq.size();
    if (base < 64 && base + bq.size() > 64) len = base + bq.size();
    fb = new[len];
    foreach (fb[i]) fb[i] = 8'h00;
    put32(0, 32'h206d6756);
    put32(4, 32'(len - 4 + end_adj));
    put32(8, ver);
    for (int i = 0; i < 6; i++) put32(ClkAddr[i], ck[i]);
    put32('h1c, (loop_rel < 0) ? 32'd0 : 32'(base + loop_rel - 'h1c));
    put32('h34, draw);
    foreach (bq[i]) fb[base+i] = bq[i];
    if (bad_magic) fb[1] = fb[1] ^ 8'h10;
    if (short_len > 0) fb = new[short_len](fb);
  endtask

  task automatic send_file(bit fixed, bit [2:0] prof, logic [4:0] rsn);
    pinned_t pin;
    pin.fixed = fixed;
    pin.v = '0;
    pin.v.profile = prof;
    pin.v.reason = rsn;
    pinned_q.push_back(pin);
    foreach (fb[i]) begin
      if (!calm && $urandom_range(99) < 13) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
      s_valid <= 1'b1;
      s_data <= fb[i];
      s_last <= (i == fb.size() - 1);
      do @(posedge clk_i); while (!s_axis_tready);
      bytes_sent++;
    end
  endtask

  task automatic directed_body(int body);
    bq.delete();
    case (body)
      BodyEnd: ;
      BodyA: put_cmd(OpFmWrite, 2);
      BodyB: put_cmd(OpBWrite, 2);
      BodyAB: begin put_cmd(OpFmWrite, 2); put_cmd(OpBWrite, 2); end
      BodyBadOp: begin put_cmd(OpWaitN, 2); put_cmd(OpBogus, 0); end
      BodyTrunc: begin put_cmd(OpFmWrite, 2); put_cmd(OpPcmSeek, 1); return; end
      BodyNoEnd: begin put_cmd(OpFmWrite, 2); return; end
      BodyBadType: put_block(OpEnd, BlkBadType, 32'd2, 2);
      BodySecond: put_block(OpEnd, BlkFmPcm, 32'h8000_0000, 0);
      BodyShortRom: put_block(OpEnd, BlkRomA, 32'd4, 4);
      BodyBadMark: put_block(8'h55, BlkFmPcm, 32'd1, 1);
      BodyTail: begin
        put_cmd(OpFmWrite, 2);
        bq.push_back(OpEnd);
        put_cmd(OpBogus, 2);
        return;
      end
      BodyPcm: begin put_block(OpEnd, BlkRomA, 32'd8, 8); put_cmd(8'h80, 0); end
      default: ;
    endcase
    bq.push_back(OpEnd);
  endtask

  task automatic random_file();
    int fam, n, r, loop_rel, end_adj, short_len;
    bit [31:0] ver, draw, len;
    bit [7:0] kind;
    int starts[$];
    bq.delete();
    fam = $urandom_range(3);
    r = $urandom_range(99);
    if (r < 6) ver = $urandom;
    else if (r < 14) ver = (r < 8) ? 32'h110 : (r < 10) ? 32'h171 : (r < 12) ? 32'h150
                         : 32'h10f;
    else ver = $urandom_range('h110, 'h171);
    r = $urandom_range(99);
    draw = (r < 50) ? 32'd0 : (r < 80) ? 32'h4c : (r < 88) ? $urandom_range(11)
         : (r < 93) ? 32'h0c : $urandom;
    for (int i = 0; i < 6; i++) begin
      r = $urandom_range(99);
      ck[i] = (r < 20) ? 32'd0 : (r < 24) ? 32'h4000_0000
            : {1'($urandom), 1'($urandom_range(6) == 0), 30'($urandom)};
    end
    n = $urandom_range(10);
    for (int k = 0; k < n; k++) begin
      starts.push_back(bq.size());
      r = $urandom_range(99);
      if (r < 10) begin
        r = $urandom_range(99);
        kind = (r < 8) ? 8'($urandom) : (fam == 1) ? ((r < 50) ? BlkRomB : BlkRomB2)
             : ((r < 50) ? BlkFmPcm : BlkRomA);
        len = (kind >= 8'h80) ? $urandom_range(8, 12) : $urandom_range(4);
        if ($urandom_range(19) == 0) len = $urandom_range(7);
        if ($urandom_range(29) == 0) len = len | 32'h8000_0000;
        put_block(($urandom_range(29) == 0) ? 8'($urandom) : OpEnd, kind, len,
                  len[31] ? 0 : int'(len));
      end else if (r < 12) put_cmd(8'($urandom), $urandom_range(3));
      else if (r < 30 || fam == 3) begin
        r = $urandom_range(3);
        if (r == 0) put_cmd(OpWaitN, 2);
        else if (r == 1) put_cmd(OpWait60, 0);
        else if (r == 2) put_cmd(OpWait50, 0);
        else put_cmd(OpWaitShort | 8'($urandom_range(15)), 0);
      end else if (fam == 1 || (fam == 2 && $urandom_range(1) == 1)) begin
        put_cmd($urandom_range(1) ? OpBWrite : OpBWrite2, 2);
      end else begin
        r = $urandom_range(9);
        case (r)
          0: put_cmd(8'h4f | 8'($urandom_range(1) << 4) ^ 8'($urandom_range(1) * 8'h1f), 1);
          1: put_cmd(OpFmWrite, 2);
          2: put_cmd(8'h53, 2);
          3: put_cmd(8'h54, 2);
          4: put_cmd(8'h55, 2);
          5: put_cmd(8'hc0, 3);
          6: put_cmd(OpPcmSeek, 4);
          default: put_cmd(8'h80 | 8'($urandom_range(15)), 0);
        endcase
      end
    end
    if ($urandom_range(9) != 0) begin
      starts.push_back(bq.size());
      bq.push_back(OpEnd);
    end
    repeat ($urandom_range(3)) bq.push_back(8'($urandom));
    r = $urandom_range(99);
    loop_rel = (r < 50 || starts.size() == 0) ? -1
             : (r < 90) ? starts[$urandom_range(starts.size() - 1)]
             : $urandom_range(bq.size());
    end_adj = ($urandom_range(9) == 0) ? $urandom_range(8) - 4 : 0;
    short_len = ($urandom_range(49) == 0) ? $urandom_range(1, 63) : 0;
    build_file(ver, draw, loop_rel, end_adj, $urandom_range(32) == 0, short_len);
  endtask

  drow_t rows[$] = '{
    '{32'h150, 32'h0c, BodyA, 1, 32'h1, -1, 0, 1'b0, 10, 1'b1, 3'd4, RsnNotVgm},
    '{32'h150, 32'h0c, BodyA, 1, 32'h1, -1, 0, 1'b1, 0, 1'b1, 3'd4, RsnNotVgm},
    '{32'h10f, 32'h00, BodyA, 1, 32'h1, -1, 0, 1'b0, 0, 1'b1, 3'd2, RsnBadVersion},
    '{32'h172, 32'h00, BodyA, 1, 32'h1, -1, 0, 1'b0, 0, 1'b1, 3'd2, RsnBadVersion},
    '{32'h150, 32'h0c, BodyA, 1, 32'h1, -1, 1, 1'b0, 0, 1'b1, 3'd4, RsnBadBounds},
    '{32'h151, 32'hffff_ffff, BodyA, 1, 32'h1, -1, 0, 1'b0, 0, 1'b1, 3'd4, RsnBadBounds},
    '{32'h150, 32'h04, BodyA, 1, 32'h1, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h110, 32'h00, BodyEnd, -1, 32'h0, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h171, 32'h0c, BodyA, 1, 32'h3fff_ffff, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h0c, BodyA, -1, 32'h0, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h0c, BodyA, 1, 32'h4000_0000, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h0c, BodyA, 1, 32'hc000_0001, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h151, 32'h4c, BodyB, 5, 32'h0080_0000, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h151, 32'h00, BodyB, 5, 32'h0080_0000, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h171, 32'h4c, BodyB, -1, 32'h0, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h4c, BodyAB, 5, 32'h1, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h0c, BodyBadOp, 1, 32'h1, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h0c, BodyTrunc, 1, 32'h1, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h0c, BodyNoEnd, 1, 32'h1, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h0c, BodyA, 1, 32'h1, 1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h0c, BodyA, 1, 32'h1, 3, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h0c, BodyBadType, 1, 32'h1, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h0c, BodySecond, 1, 32'h1, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h0c, BodyShortRom, 4, 32'h1, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h0c, BodyBadMark, 1, 32'h1, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h0c, BodyTail, 1, 32'h1, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA},
    '{32'h150, 32'h0c, BodyPcm, 4, 32'h1, -1, 0, 1'b0, 0, 1'b0, 3'd0, RsnA}
  };

  initial begin
    int files;
    files = 0;
    clear_walk();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      for (int k = 0; k < 6; k++) ck[k] = 32'h0;
      if (rows[i].clk_idx >= 0) ck[rows[i].clk_idx] = rows[i].clk_val;
      directed_body(rows[i].body);
      build_file(rows[i].ver, rows[i].draw, rows[i].loop_rel, rows[i].end_adj,
                 rows[i].bad_magic, rows[i].short_len);
      send_file(rows[i].fixed, rows[i].prof, rows[i].rsn);
    end
    while (bytes_sent < 1400 || files < 4) begin
      random_file();
      send_file(1'b0, 3'd0, RsnA);
      files++;
    end
    s_valid <= 1'b0;
    wait (verdict_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### files.f
rtl/vgm_pkg.sv
rtl/vgm_verdict.sv
rtl/vgm_stream_profile_classifier.sv
bench/vgm_stream_profile_classifier_tb.sv
